>>> rtl/lge_pkg.sv
// Shared constants, types and cell-rule functions for the life generation engine.
package lge_pkg;

  // Grid and history geometry.
  localparam int GRID_COLS     = 64;
  localparam int GRID_ROWS     = 64;
  localparam int HISTORY_DEPTH = 40;

  localparam int COL_W   = $clog2(GRID_COLS);
  localparam int ROW_W   = $clog2(GRID_ROWS);
  localparam int RING_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int POP_W   = $clog2(GRID_COLS + 1);

  // Port field widths.
  localparam int REQ_W   = 2;
  localparam int COORD_W = 6;
  localparam int GEN_W   = 32;
  localparam int COUNT_W = 13;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] PEAK_FLOOR = COUNT_W'(1);

  // Neighbor counts of the B3/S23 rule.
  localparam logic [3:0] NB_BIRTH   = 4'd3;
  localparam logic [3:0] NB_SURVIVE = 4'd2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd3;

  typedef logic [GRID_COLS-1:0] row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // transaction accepted, capture the request
    logic cell_rd;    // read the addressed row for a cell access
    logic cell_wb;    // finish a cell access (merge write or pick read bit)
    logic clear;      // empty grid and history, reset counters
    logic rd_last;    // step: fetch the last row, start the history scan
    logic rd_first;   // step: capture last row, fetch row zero
    logic rd_second;  // step: capture row zero, fetch row one
    logic walk;       // step: compute and write back one row
    logic commit;     // step: update counters and history ring
  } lge_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_row;   // the row being computed is the last one
    logic scan_done;  // history maximum scan has finished
  } lge_stat_t;

  // Next generation of one row from the rows above and below it.
  // Columns wrap around at both edges.
  function automatic row_t next_row(row_t up, row_t cur, row_t dn);
    row_t       res;
    logic [3:0] n;
    int         l;
    int         r;
    res = '0;
    for (int c = 0; c < GRID_COLS; c++) begin
      l = (c == 0) ? GRID_COLS - 1 : c - 1;
      r = (c == GRID_COLS - 1) ? 0 : c + 1;
      n = 4'(up[l]) + 4'(up[c]) + 4'(up[r]) + 4'(cur[l]) + 4'(cur[r]) +
          4'(dn[l]) + 4'(dn[c]) + 4'(dn[r]);
      res[c] = (n == NB_BIRTH) || (cur[c] && (n == NB_SURVIVE));
    end
    return res;
  endfunction

  // Number of live cells in one row, summed a byte at a time.
  function automatic logic [POP_W-1:0] row_pop(row_t v);
    logic [POP_W-1:0] total;
    logic [3:0]       part;
    total = '0;
    for (int k = 0; k < GRID_COLS; k += 8) begin
      part = '0;
      for (int b = 0; b < 8; b++) begin
        if (k + b < GRID_COLS) begin
          part = part + 4'(v[k + b]);
        end
      end
      total = total + POP_W'(part);
    end
    return total;
  endfunction

endpackage

>>> rtl/lge_ctrl.sv
// Controller state machine that sequences cell accesses, clears and generation steps.
module lge_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lge_pkg::REQ_W-1:0]    req_type_i,
  input  lge_pkg::lge_stat_t           stat_i,
  output lge_pkg::lge_cmd_t            cmd_o,
  output logic                         busy_o,
  output logic                         result_valid_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CELL_RD = 4'd1;
  localparam logic [3:0] S_CELL_WB = 4'd2;
  localparam logic [3:0] S_CLEAR   = 4'd3;
  localparam logic [3:0] S_PRE_TOP = 4'd4;
  localparam logic [3:0] S_PRE_MID = 4'd5;
  localparam logic [3:0] S_PRE_BOT = 4'd6;
  localparam logic [3:0] S_WALK    = 4'd7;
  localparam logic [3:0] S_DRAIN   = 4'd8;
  localparam logic [3:0] S_FINAL   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       valid_q, valid_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          unique case (req_type_i)
            lge_pkg::REQ_WRITE,
            lge_pkg::REQ_READ:  state_d = S_CELL_RD;
            lge_pkg::REQ_CLEAR: state_d = S_CLEAR;
            lge_pkg::REQ_STEP:  state_d = S_PRE_TOP;
          endcase
        end
      end
      S_CELL_RD: begin
        cmd_o.cell_rd = 1'b1;
        state_d       = S_CELL_WB;
      end
      S_CELL_WB: begin
        cmd_o.cell_wb = 1'b1;
        valid_d       = 1'b1;
        state_d       = S_IDLE;
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        valid_d     = 1'b1;
        state_d     = S_IDLE;
      end
      S_PRE_TOP: begin
        cmd_o.rd_last = 1'b1;
        state_d       = S_PRE_MID;
      end
      S_PRE_MID: begin
        cmd_o.rd_first = 1'b1;
        state_d        = S_PRE_BOT;
      end
      S_PRE_BOT: begin
        cmd_o.rd_second = 1'b1;
        state_d         = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.last_row) begin
          state_d = S_DRAIN;
        end
      end
      // The population of the last row is added during this cycle.
      S_DRAIN: begin
        state_d = S_FINAL;
      end
      S_FINAL: begin
        if (stat_i.scan_done) begin
          cmd_o.commit = 1'b1;
          valid_d      = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and result strobe registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;

endmodule

>>> rtl/lge_datapath.sv
// Datapath with the grid memory, row window, population counter and history ring.
module lge_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lge_pkg::lge_cmd_t             cmd_i,
  output lge_pkg::lge_stat_t            stat_o,
  input  logic [lge_pkg::REQ_W-1:0]     req_type_i,
  input  logic [lge_pkg::COORD_W-1:0]   cell_col_i,
  input  logic [lge_pkg::COORD_W-1:0]   cell_row_i,
  input  logic                          cell_value_i,
  output logic                          cell_read_o,
  output logic [lge_pkg::GEN_W-1:0]     generation_count_o,
  output logic [lge_pkg::COUNT_W-1:0]   live_count_o,
  output logic [lge_pkg::COUNT_W-1:0]   history_peak_o
);

  // Captured request.
  logic [lge_pkg::REQ_W-1:0]   req_type_q;
  logic [lge_pkg::COORD_W-1:0] req_col_q;
  logic [lge_pkg::COORD_W-1:0] req_row_q;
  logic                        req_val_q;
  logic                        in_grid;

  // Grid memory and its read port.
  lge_pkg::row_t               grid_mem [lge_pkg::GRID_ROWS];
  logic [lge_pkg::GRID_ROWS-1:0] row_vld_q;
  lge_pkg::row_t               rd_data_q;
  logic                        rd_vld_q;
  lge_pkg::row_t               rdata;
  logic                        rd_en;
  logic [lge_pkg::ROW_W-1:0]   rd_addr;
  logic                        wr_en;
  logic [lge_pkg::ROW_W-1:0]   wr_addr;
  lge_pkg::row_t               wr_data;
  lge_pkg::row_t               cell_row_new;

  // Three-row window for the generation walk.
  lge_pkg::row_t               top_q;
  lge_pkg::row_t               mid_q;
  lge_pkg::row_t               save_q;
  lge_pkg::row_t               bot;
  lge_pkg::row_t               next_w;
  lge_pkg::row_t               new_row_q;
  logic [lge_pkg::ROW_W-1:0]   row_cnt_q;
  logic [lge_pkg::ROW_W:0]     ahead_sum;
  logic [lge_pkg::ROW_W-1:0]   row_ahead;
  logic                        pop_pend_q;
  logic [lge_pkg::COUNT_W-1:0] live_acc_q;
  logic [lge_pkg::COUNT_W:0]   acc_sum;

  // History ring and its maximum scan.
  logic [lge_pkg::COUNT_W-1:0] ring_mem [lge_pkg::HISTORY_DEPTH];
  logic [lge_pkg::HISTORY_DEPTH-1:0] ring_vld_q;
  logic [lge_pkg::RING_AW-1:0] ring_pos_q;
  logic [lge_pkg::RING_AW-1:0] scan_idx_q;
  logic                        scan_on_q;
  logic                        cmp_on_q;
  logic                        cmp_skip_q;
  logic [lge_pkg::COUNT_W-1:0] ring_rd_q;
  logic                        ring_rd_vld_q;
  logic [lge_pkg::COUNT_W-1:0] scan_max_q;

  // Architectural counters and the read result.
  logic [lge_pkg::GEN_W-1:0]   gen_q;
  logic [lge_pkg::COUNT_W-1:0] live_q;
  logic [lge_pkg::COUNT_W-1:0] peak_q;
  logic                        cell_read_q;

  // Request capture on the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_type_q <= req_type_i;
      req_col_q  <= cell_col_i;
      req_row_q  <= cell_row_i;
      req_val_q  <= cell_value_i;
    end
  end

  assign in_grid = (int'(req_col_q) < lge_pkg::GRID_COLS) &&
                   (int'(req_row_q) < lge_pkg::GRID_ROWS);

  // Row two ahead of the one being computed, wrapping at the bottom.
  always_comb begin
    ahead_sum = {1'b0, row_cnt_q} + (lge_pkg::ROW_W + 1)'(2);
    if (ahead_sum >= (lge_pkg::ROW_W + 1)'(lge_pkg::GRID_ROWS)) begin
      ahead_sum = ahead_sum - (lge_pkg::ROW_W + 1)'(lge_pkg::GRID_ROWS);
    end
    row_ahead = ahead_sum[lge_pkg::ROW_W-1:0];
  end

  // Grid read address selection.
  always_comb begin
    rd_en = cmd_i.cell_rd | cmd_i.rd_last | cmd_i.rd_first | cmd_i.rd_second | cmd_i.walk;
    priority if (cmd_i.rd_last) begin
      rd_addr = lge_pkg::ROW_W'(lge_pkg::GRID_ROWS - 1);
    end else if (cmd_i.rd_first) begin
      rd_addr = '0;
    end else if (cmd_i.rd_second) begin
      rd_addr = lge_pkg::ROW_W'(1);
    end else if (cmd_i.walk) begin
      rd_addr = row_ahead;
    end else begin
      rd_addr = lge_pkg::ROW_W'(req_row_q);
    end
  end

  // A row never written since reset or clear reads as all dead.
  assign rdata = rd_vld_q ? rd_data_q : '0;

  // The last row's lower neighbor is the saved original of row zero.
  assign bot    = (row_cnt_q == lge_pkg::ROW_W'(lge_pkg::GRID_ROWS - 1)) ? save_q : rdata;
  assign next_w = lge_pkg::next_row(top_q, mid_q, bot);

  // Cell write merges the new value into the fetched row.
  always_comb begin
    cell_row_new = rdata;
    cell_row_new[lge_pkg::COL_W'(req_col_q)] = req_val_q;
  end

  // Grid write selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = lge_pkg::ROW_W'(req_row_q);
    wr_data = cell_row_new;
    if (cmd_i.walk) begin
      wr_en   = 1'b1;
      wr_addr = row_cnt_q;
      wr_data = next_w;
    end else if (cmd_i.cell_wb && (req_type_q == lge_pkg::REQ_WRITE) && in_grid) begin
      wr_en = 1'b1;
    end
  end

  // Grid memory array.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= grid_mem[rd_addr];
    end
  end

  // Row valid bits and the registered valid of the read row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        row_vld_q <= '0;
      end else if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
    end
  end

  // Window registers: rows above and at the current row, plus row zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_first) begin
      top_q <= rdata;
    end
    if (cmd_i.rd_second) begin
      mid_q  <= rdata;
      save_q <= rdata;
    end
    if (cmd_i.walk) begin
      top_q     <= mid_q;
      mid_q     <= bot;
      new_row_q <= next_w;
    end
  end

  // Saturating population sum, one row behind the walk.
  assign acc_sum = {1'b0, live_acc_q} +
                   (lge_pkg::COUNT_W + 1)'(lge_pkg::row_pop(new_row_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q  <= '0;
      pop_pend_q <= 1'b0;
      live_acc_q <= '0;
    end else begin
      if (cmd_i.rd_second) begin
        row_cnt_q <= '0;
      end else if (cmd_i.walk) begin
        row_cnt_q <= row_cnt_q + lge_pkg::ROW_W'(1);
      end
      pop_pend_q <= cmd_i.walk;
      if (cmd_i.rd_last) begin
        live_acc_q <= '0;
      end else if (pop_pend_q) begin
        live_acc_q <= (acc_sum > {1'b0, lge_pkg::COUNT_MAX}) ?
                      lge_pkg::COUNT_MAX : acc_sum[lge_pkg::COUNT_W-1:0];
      end
    end
  end

  assign stat_o.last_row  = (row_cnt_q == lge_pkg::ROW_W'(lge_pkg::GRID_ROWS - 1));
  assign stat_o.scan_done = !scan_on_q && !cmp_on_q;

  // History ring memory: commit writes, the scan reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ring_mem[ring_pos_q] <= live_acc_q;
    end
    if (scan_on_q) begin
      ring_rd_q <= ring_mem[scan_idx_q];
    end
  end

  // Maximum scan over every slot but the one the new count replaces.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_on_q     <= 1'b0;
      scan_idx_q    <= '0;
      cmp_on_q      <= 1'b0;
      cmp_skip_q    <= 1'b0;
      ring_rd_vld_q <= 1'b0;
      scan_max_q    <= lge_pkg::PEAK_FLOOR;
    end else begin
      if (cmd_i.rd_last) begin
        scan_on_q  <= 1'b1;
        scan_idx_q <= '0;
        cmp_on_q   <= 1'b0;
        scan_max_q <= lge_pkg::PEAK_FLOOR;
      end else begin
        cmp_on_q <= scan_on_q;
        if (scan_on_q) begin
          ring_rd_vld_q <= ring_vld_q[scan_idx_q];
          cmp_skip_q    <= (scan_idx_q == ring_pos_q);
          if (scan_idx_q == lge_pkg::RING_AW'(lge_pkg::HISTORY_DEPTH - 1)) begin
            scan_on_q <= 1'b0;
          end else begin
            scan_idx_q <= scan_idx_q + lge_pkg::RING_AW'(1);
          end
        end
        if (cmp_on_q && !cmp_skip_q && ring_rd_vld_q && (ring_rd_q > scan_max_q)) begin
          scan_max_q <= ring_rd_q;
        end
      end
    end
  end

  // Counters, ring position and ring valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q       <= '0;
      live_q      <= '0;
      peak_q      <= lge_pkg::PEAK_FLOOR;
      ring_pos_q  <= '0;
      ring_vld_q  <= '0;
      cell_read_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        gen_q      <= '0;
        live_q     <= '0;
        peak_q     <= lge_pkg::PEAK_FLOOR;
        ring_pos_q <= '0;
        ring_vld_q <= '0;
      end else if (cmd_i.commit) begin
        gen_q  <= gen_q + lge_pkg::GEN_W'(1);
        live_q <= live_acc_q;
        peak_q <= (live_acc_q > scan_max_q) ? live_acc_q : scan_max_q;
        ring_vld_q[ring_pos_q] <= 1'b1;
        if (ring_pos_q == lge_pkg::RING_AW'(lge_pkg::HISTORY_DEPTH - 1)) begin
          ring_pos_q <= '0;
        end else begin
          ring_pos_q <= ring_pos_q + lge_pkg::RING_AW'(1);
        end
      end
      // Only a read inside the grid returns a cell; everything else returns zero.
      if (cmd_i.latch) begin
        cell_read_q <= 1'b0;
      end else if (cmd_i.cell_wb && (req_type_q == lge_pkg::REQ_READ) && in_grid) begin
        cell_read_q <= rdata[lge_pkg::COL_W'(req_col_q)];
      end
    end
  end

  assign cell_read_o        = cell_read_q;
  assign generation_count_o = gen_q;
  assign live_count_o       = live_q;
  assign history_peak_o     = peak_q;

endmodule

>>> rtl/life_generation_engine.sv
// Top level of the toroidal Conway life engine: controller plus datapath.
//
// Each transaction is accepted when start is high and busy is low, and its single result
// appears on the result ports for one cycle with result_valid_o high; the receiver cannot
// stall it, so it must take the result in that cycle. Cell writes and reads keep busy high
// through a row read and a write-back, and a clear through its clear state. During a
// generation step the grid memory has one read port, so the walk fetches and rewrites one
// row per cycle, after the preload states (top, middle, bottom) fill the row window and
// before a drain state that adds the last row's population. The history maximum scan reads
// one ring entry per cycle alongside the walk and only adds time if the ring is deeper than
// the grid. The result strobe follows in the cycle busy drops, and a new transaction may be
// started in that same cycle. There is no clearing pass after reset: the grid and the ring
// have per-row and per-entry valid bits.
module life_generation_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [lge_pkg::REQ_W-1:0]     req_type_i,
  input  logic [lge_pkg::COORD_W-1:0]   cell_col_i,
  input  logic [lge_pkg::COORD_W-1:0]   cell_row_i,
  input  logic                          cell_value_i,
  output logic                          result_valid_o,
  output logic                          cell_read_o,
  output logic [lge_pkg::GEN_W-1:0]     generation_count_o,
  output logic [lge_pkg::COUNT_W-1:0]   live_count_o,
  output logic [lge_pkg::COUNT_W-1:0]   history_peak_o
);

  lge_pkg::lge_cmd_t  cmd;
  lge_pkg::lge_stat_t stat;

  // Sequencing of each transaction.
  lge_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .req_type_i     (req_type_i),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  // Storage and arithmetic.
  lge_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .req_type_i         (req_type_i),
    .cell_col_i         (cell_col_i),
    .cell_row_i         (cell_row_i),
    .cell_value_i       (cell_value_i),
    .cell_read_o        (cell_read_o),
    .generation_count_o (generation_count_o),
    .live_count_o       (live_count_o),
    .history_peak_o     (history_peak_o)
  );

endmodule

>>> rtl/lge_checker.sv
// Port-level checker for the life engine and its bind to the top level.
module lge_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          result_valid_o,
  input logic [lge_pkg::GEN_W-1:0]     generation_count_o,
  input logic [lge_pkg::COUNT_W-1:0]   live_count_o,
  input logic [lge_pkg::COUNT_W-1:0]   history_peak_o
);

  // An accepted transaction raises busy in the next cycle, with no result strobe yet.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("busy not raised after an accepted transaction");

  // A result is only shown once the block has finished its work.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // Two results are never back to back.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // With no transaction in flight or arriving, the counters hold.
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> ($stable(generation_count_o) && $stable(live_count_o) &&
                           $stable(history_peak_o)))
    else $error("counters changed while idle");

  // The history peak never drops below one.
  a_peak_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    history_peak_o != '0)
    else $error("history peak is zero");

endmodule

bind life_generation_engine lge_checker u_lge_checker (.*);
